/* rtl/ssp_pkg.sv */
// Shared types, constants and register map for the servo slew pulse mapper.
package ssp_pkg;

	localparam int POS_W      = 15;
	localparam int MAXP_W     = 14;
	localparam int PULSE_W    = 15;
	localparam int BITS_W     = 5;
	localparam int PERIOD_W   = 16;
	localparam int TOL_W      = 8;
	localparam int SPEED_W    = 16;
	localparam int DUTY_W     = 20;
	localparam int STEP_MUL   = 82;
	localparam int STEP_SHIFT = 12;
	localparam int STEP_W     = 11;
	localparam int SPD_PROD_W = SPEED_W + 7;
	localparam int MAG_W      = 16;
	localparam int P1_W       = 30;
	localparam int P2_W       = 31;
	localparam int NUM_W      = 32;
	localparam int DIV_W      = 51;
	localparam int DIV_STEPS  = DUTY_W + 1;
	localparam int CNT_W      = 5;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam logic [BITS_W-1:0] DUTY_BITS_MAX = BITS_W'(DUTY_W);

	localparam logic signed [POS_W-1:0] RST_MIN_POS   = -15'sd10723;
	localparam logic [MAXP_W-1:0]       RST_MAX_POS   = 14'd10723;
	localparam logic [PULSE_W-1:0]      RST_MIN_PULSE = 15'd351;
	localparam logic [PULSE_W-1:0]      RST_MAX_PULSE = 15'd2640;
	localparam logic [BITS_W-1:0]       RST_DUTY_BITS = 5'd14;
	localparam logic [PERIOD_W-1:0]     RST_PERIOD    = 16'd20000;
	localparam logic [TOL_W-1:0]        RST_TOL       = 8'd20;

	typedef enum logic [2:0] {
		REG_MIN_POS   = 3'd0,
		REG_MAX_POS   = 3'd1,
		REG_MIN_PULSE = 3'd2,
		REG_MAX_PULSE = 3'd3,
		REG_DUTY_BITS = 3'd4,
		REG_PERIOD    = 3'd5,
		REG_TOL       = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] min_position;
		logic [MAXP_W-1:0]       max_position;
		logic [PULSE_W-1:0]      min_pulse_us;
		logic [PULSE_W-1:0]      max_pulse_us;
		logic [BITS_W-1:0]       duty_bits;
		logic [PERIOD_W-1:0]     period_us;
		logic [TOL_W-1:0]        tolerance;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_RANGE,
		ST_SUM,
		ST_DIV,
		ST_WB,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic ld_cmd;
		logic calc;
		logic rng;
		logic sum;
		logic div;
		logic wb;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic near;
		logic ok;
		logic num_pos;
	} dp_sts_t;

endpackage

/* rtl/ssp_in_if.sv */
// Input channel: command or tick beat with valid/ready.
interface ssp_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [14:0] target;
	logic [15:0]        speed;

	modport source (output valid, output mode, output target, output speed, input ready);
	modport sink   (input valid, input mode, input target, input speed, output ready);
endinterface

/* rtl/ssp_out_if.sv */
// Output channel: result beat with valid/ready.
interface ssp_out_if;
	logic               valid;
	logic               ready;
	logic [19:0]        duty;
	logic               in_range;
	logic signed [14:0] position;
	logic               done_res;

	modport source (output valid, output duty, output in_range, output position,
		output done_res, input ready);
	modport sink   (input valid, input duty, input in_range, input position,
		input done_res, output ready);
endinterface

/* rtl/ssp_regs.sv */
// APB configuration register file.
module ssp_regs import ssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_position <= RST_MIN_POS;
			cfg_q.max_position <= RST_MAX_POS;
			cfg_q.min_pulse_us <= RST_MIN_PULSE;
			cfg_q.max_pulse_us <= RST_MAX_PULSE;
			cfg_q.duty_bits    <= RST_DUTY_BITS;
			cfg_q.period_us    <= RST_PERIOD;
			cfg_q.tolerance    <= RST_TOL;
		end else if (wr) begin
			unique case (idx)
				REG_MIN_POS:   cfg_q.min_position <= $signed(pwdata[POS_W-1:0]);
				REG_MAX_POS:   cfg_q.max_position <= pwdata[MAXP_W-1:0];
				REG_MIN_PULSE: cfg_q.min_pulse_us <= pwdata[PULSE_W-1:0];
				REG_MAX_PULSE: cfg_q.max_pulse_us <= pwdata[PULSE_W-1:0];
				REG_DUTY_BITS: cfg_q.duty_bits    <= pwdata[BITS_W-1:0];
				REG_PERIOD:    cfg_q.period_us    <= pwdata[PERIOD_W-1:0];
				REG_TOL:       cfg_q.tolerance    <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN_POS:   prdata = {{(DATA_W-POS_W){cfg_q.min_position[POS_W-1]}},
				cfg_q.min_position};
			REG_MAX_POS:   prdata = {{(DATA_W-MAXP_W){1'b0}}, cfg_q.max_position};
			REG_MIN_PULSE: prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_q.min_pulse_us};
			REG_MAX_PULSE: prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_q.max_pulse_us};
			REG_DUTY_BITS: prdata = {{(DATA_W-BITS_W){1'b0}}, cfg_q.duty_bits};
			REG_PERIOD:    prdata = {{(DATA_W-PERIOD_W){1'b0}}, cfg_q.period_us};
			REG_TOL:       prdata = {{(DATA_W-TOL_W){1'b0}}, cfg_q.tolerance};
			default:       prdata = '0;
		endcase
	end

endmodule

/* rtl/ssp_ctrl.sv */
// Sequencer: walks one tick through step, range, map and divide phases.
module ssp_ctrl import ssp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_mode,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             div_last;

	assign div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && in_mode) state_nxt = ST_CALC;
			ST_CALC:  state_nxt = sts.near ? ST_IDLE : ST_RANGE;
			ST_RANGE: state_nxt = sts.ok ? ST_SUM : ST_FIN;
			ST_SUM:   state_nxt = sts.num_pos ? ST_DIV : ST_FIN;
			ST_DIV:   if (div_last) state_nxt = ST_WB;
			ST_WB:    state_nxt = ST_FIN;
			ST_FIN:   if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.ld_cmd = in_valid && !in_mode;
			end
			ST_CALC:  cmd.calc = 1'b1;
			ST_RANGE: cmd.rng  = 1'b1;
			ST_SUM:   cmd.sum  = 1'b1;
			ST_DIV:   cmd.div  = 1'b1;
			ST_WB:    cmd.wb   = 1'b1;
			ST_FIN:   cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cmd.div ? cnt_q + 1'b1 : '0;
			priority if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/ssp_dp.sv */
// Datapath: position state, slew step, duty mapping and restoring divider.
module ssp_dp import ssp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  ctl_cmd_t                cmd,
	input  logic signed [POS_W-1:0] target,
	input  logic [SPEED_W-1:0]      speed,
	output dp_sts_t                 sts,
	output logic [DUTY_W-1:0]       duty,
	output logic                    in_range,
	output logic signed [POS_W-1:0] position,
	output logic                    done_res
);

	// architectural state
	logic signed [POS_W-1:0] goal_q, pos_q;
	logic [STEP_W-1:0]       step_q;
	logic [DUTY_W-1:0]       duty_held_q;

	// working registers
	logic                    ok_q, done_q;
	logic [P1_W-1:0]         p1_q, den_q;
	logic signed [P2_W-1:0]  p2_q;
	logic [DIV_W-1:0]        rem_q, dvs_q;
	logic [DIV_STEPS-1:0]    quo_q;

	// result register
	logic [DUTY_W-1:0]       duty_q;
	logic                    in_range_q, done_res_q;
	logic signed [POS_W-1:0] position_q;

	logic [SPD_PROD_W-1:0]   spd_prod;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]        mag;
	logic                    over;
	logic [MAG_W-1:0]        next_w;
	logic [MAXP_W-1:0]       maxp;
	logic [PERIOD_W-1:0]     per;
	logic [BITS_W-1:0]       bits;
	logic [PULSE_W:0]        lo_hi;
	logic signed [PULSE_W:0] span;
	logic [P1_W-1:0]         p1_w, den_w;
	logic signed [P2_W-1:0]  p2_w;
	logic signed [NUM_W-1:0] num;
	logic                    ok_w, ge;

	assign spd_prod = {{(SPD_PROD_W-SPEED_W){1'b0}}, speed} * SPD_PROD_W'(STEP_MUL);

	// distance to goal; reused after the step as the remaining distance
	assign diff = {goal_q[POS_W-1], goal_q} - {pos_q[POS_W-1], pos_q};
	assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
	assign over = {{(MAG_W-STEP_W){1'b0}}, step_q} >= mag;

	always_comb begin
		priority if (over) begin
			next_w = {goal_q[POS_W-1], goal_q};
		end else if (!diff[MAG_W-1]) begin
			next_w = {pos_q[POS_W-1], pos_q} + {{(MAG_W-STEP_W){1'b0}}, step_q};
		end else begin
			next_w = {pos_q[POS_W-1], pos_q} - {{(MAG_W-STEP_W){1'b0}}, step_q};
		end
	end

	assign maxp = (cfg.max_position == '0) ? MAXP_W'(1) : cfg.max_position;
	assign per  = (cfg.period_us == '0) ? PERIOD_W'(1) : cfg.period_us;
	assign bits = (cfg.duty_bits > DUTY_BITS_MAX) ? DUTY_BITS_MAX : cfg.duty_bits;

	assign ok_w = (pos_q >= cfg.min_position) &&
		($signed({pos_q[POS_W-1], pos_q}) <= $signed({2'b00, maxp}));

	assign lo_hi = {1'b0, cfg.min_pulse_us} + {1'b0, cfg.max_pulse_us};
	assign span  = $signed({1'b0, cfg.max_pulse_us}) - $signed({1'b0, cfg.min_pulse_us});
	assign p1_w  = {{(P1_W-PULSE_W-1){1'b0}}, lo_hi} * {{(P1_W-MAXP_W){1'b0}}, maxp};
	assign den_w = {{(P1_W-MAXP_W){1'b0}}, maxp} * {{(P1_W-PERIOD_W){1'b0}}, per};
	assign p2_w  = $signed({{(P2_W-POS_W){pos_q[POS_W-1]}}, pos_q}) *
		$signed({{(P2_W-PULSE_W-1){span[PULSE_W]}}, span});

	assign num = $signed({2'b00, p1_q}) + $signed({p2_q[P2_W-1], p2_q});
	assign ge  = rem_q >= dvs_q;

	assign sts.near    = mag <= {{(MAG_W-TOL_W){1'b0}}, cfg.tolerance};
	assign sts.ok      = ok_w;
	assign sts.num_pos = !num[NUM_W-1] && (num != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q      <= '0;
			step_q      <= '0;
			pos_q       <= '0;
			duty_held_q <= '0;
		end else begin
			if (cmd.ld_cmd) begin
				goal_q <= target;
				step_q <= spd_prod[STEP_SHIFT +: STEP_W];
			end
			if (cmd.calc && !sts.near) begin
				pos_q <= next_w[POS_W-1:0];
			end
			if (cmd.sum && !sts.num_pos) begin
				duty_held_q <= '0;
			end
			if (cmd.wb) begin
				duty_held_q <= quo_q[DIV_STEPS-1] ? '1 : quo_q[DUTY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rng) begin
			ok_q   <= ok_w;
			done_q <= sts.near;
			p1_q   <= p1_w;
			p2_q   <= p2_w;
			den_q  <= den_w;
		end
		if (cmd.sum) begin
			rem_q <= {{(DIV_W-NUM_W+1){1'b0}}, num[NUM_W-2:0]} << bits;
			dvs_q <= {den_q, 1'b0, {DUTY_W{1'b0}}};
			quo_q <= '0;
		end
		if (cmd.div) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
		end
		if (cmd.out_load) begin
			duty_q     <= duty_held_q;
			in_range_q <= ok_q;
			position_q <= pos_q;
			done_res_q <= done_q;
		end
	end

	assign duty     = duty_q;
	assign in_range = in_range_q;
	assign position = position_q;
	assign done_res = done_res_q;

endmodule

/* rtl/servo_slew_pulse_mapper.sv */
// Servo slew limiter with PWM duty mapping, top level.
// Command beat: taken while idle, no result. Tick inside tolerance: no result.
// Tick out of limits: result after the range state; in limits with a mapped value at or
// below zero: after sum; else after the 21-step restoring divider (one bit per cycle).
// One beat in flight; the result register lets the next beat enter while a result waits.
// arst_n clears goal, step, position, held duty and all control; config takes reset values.
module servo_slew_pulse_mapper import ssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ssp_in_if.sink            cmd,
	ssp_out_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg;
	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// register file; writes land on the APB access phase
	ssp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer owns the handshakes and the result-valid flag
	ssp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_mode   (cmd.mode),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (ctl)
	);

	// datapath holds servo state and the result payload register
	ssp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (ctl),
		.target   (cmd.target),
		.speed    (cmd.speed),
		.sts      (sts),
		.duty     (res.duty),
		.in_range (res.in_range),
		.position (res.position),
		.done_res (res.done_res)
	);

	// an accepted beat never yields a result on the very next edge
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !$rose(res.valid))
		else $error("result appeared right after input beat");

	// a new result only follows a busy cycle of the sequencer
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(!cmd.ready))
		else $error("result rose without work in progress");

	// an in-range result lies inside the configured limits (a zero maximum counts as one)
	a_in_range_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.in_range) |->
		((res.position >= cfg.min_position) &&
		(($signed({res.position[14], res.position}) <= $signed({2'b00, cfg.max_position}))
		|| ($signed(res.position) <= 15'sd1))))
		else $error("in-range result outside position limits");

endmodule
